@@ sv/adsr_pkg.sv @@
// Shared types and constants for the ADSR envelope block.
`default_nettype none
package adsr_pkg;

   localparam int unsigned VelW   = 16;
   localparam int unsigned TimeW  = 25;
   localparam int unsigned LenW   = 24;
   localparam int unsigned LvlW   = 16;
   localparam int unsigned QuoW   = 16;
   localparam int unsigned DvdW   = LenW + QuoW;
   localparam logic [LvlW-1:0] FullScale = 16'h8000;

   // Register indexes on the configuration port
   localparam logic [7:0] RegAttack  = 8'd0;
   localparam logic [7:0] RegDecay   = 8'd1;
   localparam logic [7:0] RegSustain = 8'd2;
   localparam logic [7:0] RegRelease = 8'd3;

   typedef struct packed {
      logic [LenW-1:0] attack_len;
      logic [LenW-1:0] decay_len;
      logic [LvlW-1:0] sustain_lvl;
      logic [LenW-1:0] release_len;
   } cfg_type;

   // One classified audio block, handed from front to back
   typedef struct packed {
      logic                    active;
      logic [VelW-1:0]         velocity;
      logic signed [TimeW-1:0] start_time;
      logic signed [TimeW-1:0] stop_time;
   } blk_type;

   function automatic logic [LvlW-1:0] sat_q15(input logic [LvlW-1:0] v);
      sat_q15 = (v > FullScale) ? FullScale : v;
   endfunction

endpackage
`default_nettype wire

@@ sv/adsr_front.sv @@
// Front end: note phase tracking and classification of each request.
`default_nettype none
module adsr_front (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_fire,
   input  wire logic [adsr_pkg::VelW-1:0]         velocity,
   input  wire logic signed [adsr_pkg::TimeW-1:0] start_time,
   input  wire logic signed [adsr_pkg::TimeW-1:0] stop_time,
   input  wire logic [adsr_pkg::LenW-1:0]         release_len,
   output adsr_pkg::blk_type                      blk
);

   typedef enum logic [2:0] {
      PH_NOT_STARTED = 3'b001,
      PH_STARTED     = 3'b010,
      PH_ENDED       = 3'b100
   } phase_type;

   phase_type phase_ff, phase_in;
   logic      now_started;
   logic      past_release;

   // Start a note, then end it once the release has run out
   always_comb begin
      now_started  = (phase_ff == PH_STARTED) ||
                     ((phase_ff == PH_NOT_STARTED) && (velocity != '0) && !start_time[24]);
      past_release = $signed(stop_time) > $signed({1'b0, release_len});
      phase_in     = phase_ff;
      if (req_fire) begin
         if (now_started) begin
            phase_in = past_release ? PH_ENDED : PH_STARTED;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_NOT_STARTED;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_comb begin
      blk.active     = now_started && !past_release;
      blk.velocity   = adsr_pkg::sat_q15(velocity);
      blk.start_time = start_time;
      blk.stop_time  = stop_time;
   end

endmodule
`default_nettype wire

@@ sv/adsr_queue.sv @@
// Two-entry queue of classified blocks between front and back.
`default_nettype none
module adsr_queue (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  push,
   input  wire adsr_pkg::blk_type push_data,
   output logic       full,
   input  wire logic  pop,
   output logic       head_valid,
   output adsr_pkg::blk_type head
);

   adsr_pkg::blk_type mem_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head       = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Advance pointers and track fill
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end

endmodule
`default_nettype wire

@@ sv/adsr_back.sv @@
// Back end: per-sample envelope sequencer with a shared radix-2 divider.
`default_nettype none
module adsr_back #(
   parameter int unsigned SamplesPerBlock = 64
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire adsr_pkg::cfg_type cfg,
   input  wire logic             head_valid,
   input  wire adsr_pkg::blk_type head,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic [15:0]           rsp_tdata,
   output logic                  rsp_tlast
);

   localparam int unsigned IdxW = (SamplesPerBlock > 1) ? $clog2(SamplesPerBlock) : 1;
   localparam logic [IdxW-1:0] LastIdx = IdxW'(SamplesPerBlock - 1);
   localparam int unsigned LenW = adsr_pkg::LenW;
   localparam int unsigned LvlW = adsr_pkg::LvlW;
   localparam int unsigned QuoW = adsr_pkg::QuoW;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_SETUP = 6'b000010,
      ST_MUL   = 6'b000100,
      ST_DIV   = 6'b001000,
      ST_REL   = 6'b010000,
      ST_OUT   = 6'b100000
   } state_type;

   typedef enum logic [2:0] {
      DM_ATTACK  = 3'b001,
      DM_DECAY   = 3'b010,
      DM_RELEASE = 3'b100
   } dmode_type;

   state_type        state_ff, state_in;
   dmode_type        dmode_ff;
   logic [IdxW-1:0]  idx_ff;
   logic signed [25:0] u_ff;
   logic [LvlW-1:0]  x_ff;
   logic [LvlW-1:0]  lvl_ff;
   logic [LvlW-1:0]  mul_a_ff;
   logic [LenW-1:0]  mul_b_ff;
   logic [LenW-1:0]  dsr_ff;
   logic [LenW-1:0]  rem_ff;
   logic [QuoW-1:0]  quo_ff;
   logic [4:0]       cnt_ff;
   logic             rsp_valid_ff;
   logic [15:0]      rsp_data_ff;
   logic             rsp_last_ff;

   logic signed [25:0] t_sum, u_sum, idx_ext;
   logic [24:0]      t_mag, ad_sum, t_minus_a;
   logic             lt_a, lt_ad;
   logic [LvlW-1:0]  s_sat;
   logic [24:0]      trial;
   logic             ge;
   logic             u_lt_r;
   logic [24:0]      r_minus_u;
   logic [31:0]      vel_prod;
   logic [39:0]      prod;
   logic [38:0]      atk_dvd;
   logic             out_free;

   // Sample times, segment selection, divider trial, products and output handshake
   always_comb begin
      idx_ext   = 26'(idx_ff);
      t_sum     = $signed({head.start_time[24], head.start_time}) + idx_ext;
      u_sum     = head.stop_time[24] ? $signed({1'b1, head.stop_time})
                                     : $signed({1'b0, head.stop_time}) + idx_ext;
      t_mag     = t_sum[24:0];
      ad_sum    = {1'b0, cfg.attack_len} + {1'b0, cfg.decay_len};
      lt_a      = t_mag < {1'b0, cfg.attack_len};
      lt_ad     = t_mag < ad_sum;
      t_minus_a = t_mag - {1'b0, cfg.attack_len};
      s_sat     = adsr_pkg::sat_q15(cfg.sustain_lvl);
      atk_dvd   = {t_mag[23:0], 15'd0};
      u_lt_r    = u_ff[24:0] < {1'b0, cfg.release_len};
      r_minus_u = {1'b0, cfg.release_len} - u_ff[24:0];
      trial     = {rem_ff, quo_ff[QuoW-1]};
      ge        = trial >= {1'b0, dsr_ff};
      prod      = 40'(mul_a_ff) * 40'(mul_b_ff);
      vel_prod  = 32'(head.velocity) * 32'(lvl_ff);
      out_free  = !rsp_valid_ff || rsp_tready;
   end

   always_comb begin
      state_in = state_ff;
      pop      = 1'b0;
      case (state_ff)
         ST_IDLE:  if (head_valid) state_in = ST_SETUP;
         ST_SETUP: begin
            if (!head.active || t_sum[25]) state_in = head.active ? ST_REL : ST_OUT;
            else if (lt_a)  state_in = ST_DIV;
            else if (lt_ad) state_in = ST_MUL;
            else            state_in = ST_REL;
         end
         ST_MUL: state_in = ST_DIV;
         ST_DIV: if (cnt_ff == 5'd0) state_in = (dmode_ff == DM_RELEASE) ? ST_OUT : ST_REL;
         ST_REL: state_in = (!u_ff[25] && u_lt_r) ? ST_MUL : ST_OUT;
         ST_OUT: begin
            if (out_free) begin
               pop      = (idx_ff == LastIdx);
               state_in = pop ? ST_IDLE : ST_SETUP;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_OUT && out_free) begin
            idx_ff       <= pop ? '0 : idx_ff + 1'b1;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath: segment setup, product, divide steps, release setup, output
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_SETUP: begin
            u_ff <= u_sum;
            if (!head.active) begin
               lvl_ff <= '0;
            end else if (t_sum[25]) begin
               x_ff <= '0;
            end else if (lt_a) begin
               dmode_ff <= DM_ATTACK;
               dsr_ff   <= cfg.attack_len;
               rem_ff   <= LenW'({1'b0, atk_dvd} >> QuoW);
               quo_ff   <= atk_dvd[QuoW-1:0];
               cnt_ff   <= 5'(QuoW);
            end else if (lt_ad) begin
               dmode_ff <= DM_DECAY;
               dsr_ff   <= cfg.decay_len;
               mul_a_ff <= adsr_pkg::FullScale - s_sat;
               mul_b_ff <= t_minus_a[LenW-1:0];
            end else begin
               x_ff <= s_sat;
            end
         end
         ST_MUL: begin
            rem_ff <= prod[39:QuoW];
            quo_ff <= prod[QuoW-1:0];
            cnt_ff <= 5'(QuoW);
         end
         ST_DIV: begin
            if (cnt_ff != 5'd0) begin
               rem_ff <= ge ? LenW'(trial - {1'b0, dsr_ff}) : trial[LenW-1:0];
               quo_ff <= {quo_ff[QuoW-2:0], ge};
               cnt_ff <= cnt_ff - 5'd1;
            end else begin
               case (dmode_ff)
                  DM_ATTACK:  x_ff   <= quo_ff;
                  DM_DECAY:   x_ff   <= adsr_pkg::FullScale - quo_ff;
                  DM_RELEASE: lvl_ff <= quo_ff;
                  default:    x_ff   <= quo_ff;
               endcase
            end
         end
         ST_REL: begin
            if (u_ff[25]) begin
               lvl_ff <= x_ff;
            end else if (u_lt_r) begin
               dmode_ff <= DM_RELEASE;
               dsr_ff   <= cfg.release_len;
               mul_a_ff <= x_ff;
               mul_b_ff <= r_minus_u[LenW-1:0];
            end else begin
               lvl_ff <= '0;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_data_ff <= vel_prod[30:15];
               rsp_last_ff <= (idx_ff == LastIdx);
            end
         end
         default: ;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_pop_in_out: assert property (@(posedge clock) disable iff (reset)
      pop |-> (state_ff == ST_OUT) && head_valid)
      else $error("block popped outside output step");
   a_lvl_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) && head.active |-> lvl_ff <= adsr_pkg::FullScale)
      else $error("envelope level above full scale");
   a_last_pop: assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_tvalid && rsp_tlast)
      else $error("block end without last sample");
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) && (cnt_ff == 5'd0) |=> state_ff != ST_DIV)
      else $error("divider overran its step count");

endmodule
`default_nettype wire

@@ sv/adsr_envelope_block.sv @@
// Top level: configuration registers, front end, block queue and back end.
// With the back end idle, the first sample of an accepted request passes through the queue,
// one idle step, then setup, segment math and output.
// A sounding sample takes at most two divider passes, two multiply steps, and the setup,
// release and output steps, a silent one only setup and output, plus one idle step per
// request of SamplesPerBlock samples; output waits while a held sample is not yet taken.
// Reset (synchronous, active high) sets the note phase to not started and loads
// the default attack, decay, sustain and release registers.
`default_nettype none
module adsr_envelope_block #(
   parameter int unsigned SamplesPerBlock = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [71:0] req_tdata,   // velocity[15:0], start_time[40:16], stop_time[65:41]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // sample_out[15:0]
   output logic             rsp_tlast,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_index,
   input  wire logic [23:0] csr_data
);

   adsr_pkg::cfg_type cfg_ff;
   adsr_pkg::blk_type front_blk, head;
   logic req_fire, full, head_valid, pop;

   assign csr_ready  = 1'b1;
   assign req_tready = !full;
   assign req_fire   = req_tvalid && req_tready;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.attack_len  <= 24'd960;
         cfg_ff.decay_len   <= 24'd1440;
         cfg_ff.sustain_lvl <= 16'd16384;
         cfg_ff.release_len <= 24'd48000;
      end else if (csr_valid) begin
         case (csr_index)
            adsr_pkg::RegAttack:  cfg_ff.attack_len  <= csr_data;
            adsr_pkg::RegDecay:   cfg_ff.decay_len   <= csr_data;
            adsr_pkg::RegSustain: cfg_ff.sustain_lvl <= csr_data[15:0];
            adsr_pkg::RegRelease: cfg_ff.release_len <= csr_data;
            default: ;
         endcase
      end
   end

   adsr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_fire    (req_fire),
      .velocity    (req_tdata[15:0]),
      .start_time  (req_tdata[40:16]),
      .stop_time   (req_tdata[65:41]),
      .release_len (cfg_ff.release_len),
      .blk         (front_blk)
   );

   adsr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_fire),
      .push_data  (front_blk),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   adsr_back #(.SamplesPerBlock(SamplesPerBlock)) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire
